[rtl/qbc_pkg.sv]
// Shared types, constants and node helpers for the quad-tree barrier combiner.
package qbc_pkg;

	localparam int SIDE       = 16;
	localparam int MAX_TASKS  = 8;
	localparam int LEVELS     = 5;
	localparam int NODE_COUNT = 341;
	localparam int ADDR_W     = 9;
	localparam int NODE_W     = 5;

	localparam logic [ADDR_W-1:0] OFS_L1 = 9'd256;
	localparam logic [ADDR_W-1:0] OFS_L2 = 9'd320;
	localparam logic [ADDR_W-1:0] OFS_L3 = 9'd336;
	localparam logic [ADDR_W-1:0] OFS_L4 = 9'd340;

	typedef enum logic [1:0] {
		CFG_MESH_WIDTH  = 2'd0,
		CFG_MESH_HEIGHT = 2'd1,
		CFG_TASKS       = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [3:0] arrive_x;
		logic [3:0] arrive_y;
	} in_word_t;

	typedef struct packed {
		logic [2:0] nodes_completed;
		logic       all_released;
		logic       root_sense;
		logic       bad_arrival;
	} out_word_t;

	// Effective configuration seen by the walker
	typedef struct packed {
		logic [4:0] w;
		logic [4:0] h;
		logic [3:0] leaf_ar;
		logic [2:0] top;
	} cfg_eff_t;

	// Packed node address: levels stored back to back, row-major inside a level
	function automatic logic [ADDR_W-1:0] node_addr(input logic [2:0] lv,
		input logic [3:0] x, input logic [3:0] y);
		logic [ADDR_W-1:0] a;
		begin
			case (lv)
				3'd0: a = {1'b0, y, x};
				3'd1: a = OFS_L1 + {3'b000, y[3:1], x[3:1]};
				3'd2: a = OFS_L2 + {5'b00000, y[3:2], x[3:2]};
				3'd3: a = OFS_L3 + {7'b0000000, y[3], x[3]};
				default: a = OFS_L4;
			endcase
			return a;
		end
	endfunction

	// Children of an inner node whose origin lies inside the mesh
	function automatic logic [3:0] inner_arity(input logic [2:0] lv,
		input logic [3:0] x, input logic [3:0] y,
		input logic [4:0] w, input logic [4:0] h);
		logic [4:0] half;
		logic [4:0] ox;
		logic [4:0] oy;
		logic [4:0] cx;
		logic [4:0] cy;
		logic [3:0] n;
		logic [3:0] mask;
		begin
			half = 5'd1 << (lv - 3'd1);
			mask = 4'hF << lv;
			ox   = {1'b0, x & mask};
			oy   = {1'b0, y & mask};
			n    = 4'd0;
			for (int i = 0; i < 4; i++) begin
				cx = ox + ((i % 2 == 1) ? half : 5'd0);
				cy = oy + ((i / 2 == 1) ? half : 5'd0);
				if (cx < w && cy < h) begin
					n = n + 4'd1;
				end
			end
			return n;
		end
	endfunction

endpackage

[rtl/qbc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module qbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/qbc_walker.sv]
// Node-state sequencer: clears the node RAM, then climbs each arrival up the tree.
module qbc_walker (
	input  logic              clk,
	input  logic              arst_n,
	input  qbc_pkg::cfg_eff_t cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  qbc_pkg::in_word_t in_data,
	output logic              res_valid,
	input  logic              res_ready,
	output qbc_pkg::out_word_t res
);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_STEP  = 5'b00100,
		S_ROOT  = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	localparam logic [qbc_pkg::ADDR_W-1:0] CLR_LAST =
		qbc_pkg::ADDR_W'(qbc_pkg::NODE_COUNT - 1);

	state_t                       state_q;
	logic [qbc_pkg::ADDR_W-1:0]   clr_q;
	logic [3:0]                   x_q;
	logic [3:0]                   y_q;
	logic [2:0]                   lv_q;
	logic [2:0]                   done_q;
	logic                         rel_q;
	logic                         rs_q;
	logic                         bad_q;

	logic                         we;
	logic [qbc_pkg::ADDR_W-1:0]   waddr;
	logic [qbc_pkg::NODE_W-1:0]   wdata;
	logic [qbc_pkg::ADDR_W-1:0]   raddr;
	logic [qbc_pkg::NODE_W-1:0]   rdata;

	logic [3:0]                   ar;
	logic [4:0]                   cnt;
	logic                         hit;
	logic                         at_top;
	logic                         bad_in;
	logic [qbc_pkg::ADDR_W-1:0]   root_addr;

	qbc_ram #(
		.WIDTH (qbc_pkg::NODE_W),
		.DEPTH (qbc_pkg::NODE_COUNT)
	) u_node_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		root_addr = qbc_pkg::node_addr(cfg.top, 4'd0, 4'd0);
		bad_in    = ({1'b0, in_data.arrive_x} >= cfg.w) || ({1'b0, in_data.arrive_y} >= cfg.h);
		ar        = (lv_q == 3'd0) ? cfg.leaf_ar
		            : qbc_pkg::inner_arity(lv_q, x_q, y_q, cfg.w, cfg.h);
		cnt       = {1'b0, rdata[3:0]} + 5'd1;
		hit       = cnt >= {1'b0, ar};
		at_top    = lv_q == cfg.top;
		in_ready  = state_q == S_IDLE;
		res_valid = state_q == S_DONE;
		res.nodes_completed = done_q;
		res.all_released    = rel_q;
		res.root_sense      = rs_q;
		res.bad_arrival     = bad_q;

		we    = 1'b0;
		waddr = qbc_pkg::node_addr(lv_q, x_q, y_q);
		wdata = hit ? {~rdata[4], 4'd0} : {rdata[4], cnt[3:0]};
		raddr = root_addr;
		case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			S_IDLE: begin
				raddr = bad_in ? root_addr
				        : qbc_pkg::node_addr(3'd0, in_data.arrive_x, in_data.arrive_y);
			end
			S_STEP: begin
				we = 1'b1;
				if (hit && !at_top) begin
					raddr = qbc_pkg::node_addr(lv_q + 3'd1, x_q, y_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= bad_in ? S_ROOT : S_STEP;
					end
				end
				S_STEP: begin
					if (at_top || !hit) begin
						state_q <= (at_top) ? S_DONE : S_ROOT;
					end
				end
				S_ROOT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Walk payload: coordinates, level and the result under construction
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				x_q    <= in_data.arrive_x;
				y_q    <= in_data.arrive_y;
				bad_q  <= bad_in;
				lv_q   <= 3'd0;
				done_q <= 3'd0;
				rel_q  <= 1'b0;
			end
			S_STEP: begin
				if (hit) begin
					done_q <= done_q + 3'd1;
					lv_q   <= lv_q + 3'd1;
					if (at_top) begin
						rel_q <= 1'b1;
						rs_q  <= ~rdata[4];
					end
				end else if (at_top) begin
					rs_q <= rdata[4];
				end
			end
			S_ROOT: begin
				rs_q <= rdata[4];
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/quadtree_barrier_combiner_core.sv]
// Top level of the quad-tree barrier combiner: config registers, walker, output register.
//
//  channel | signals                                  | word
//  --------+------------------------------------------+--------------------------------
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| register index + 5-bit value
//  in      | in_valid, in_ready, in_data              | arrive_x, arrive_y
//  out     | out_valid, out_ready, out_data           | nodes_completed, all_released,
//          |                                          | root_sense, bad_arrival
//
// One arrival is accepted in S_IDLE, then gets one read-modify-write step per tree level
// climbed (up to five), one extra root read when the arrival stops below the root or is
// out of mesh, and a handoff in S_DONE that waits until the output register can load.
// After reset a clearing pass writes all 341 node entries, one per cycle; in_ready stays
// low for the whole pass while configuration writes are still taken.
// A stalled out channel holds its word in the output register; the walker takes the next
// arrival meanwhile and waits only if its own result is ready before the register frees.
module quadtree_barrier_combiner_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [4:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  qbc_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output qbc_pkg::out_word_t out_data
);

	logic [4:0]         mesh_width_q;
	logic [4:0]         mesh_height_q;
	logic [3:0]         tasks_q;
	qbc_pkg::cfg_eff_t  cfg_eff;
	logic [4:0]         side_max;

	logic               res_valid;
	logic               res_ready;
	qbc_pkg::out_word_t res;
	logic               out_valid_q;
	qbc_pkg::out_word_t out_data_q;

	// Configuration port never stalls
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mesh_width_q  <= 5'd16;
			mesh_height_q <= 5'd16;
			tasks_q       <= 4'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				qbc_pkg::CFG_MESH_WIDTH:  mesh_width_q  <= cfg_data;
				qbc_pkg::CFG_MESH_HEIGHT: mesh_height_q <= cfg_data;
				qbc_pkg::CFG_TASKS:       tasks_q       <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// Clamp sides and leaf arity, derive the root level from the larger side
	always_comb begin
		cfg_eff.w = (mesh_width_q > 5'(qbc_pkg::SIDE)) ? 5'(qbc_pkg::SIDE) : mesh_width_q;
		cfg_eff.h = (mesh_height_q > 5'(qbc_pkg::SIDE)) ? 5'(qbc_pkg::SIDE) : mesh_height_q;
		if (tasks_q == 4'd0) begin
			cfg_eff.leaf_ar = 4'd1;
		end else if (tasks_q > 4'(qbc_pkg::MAX_TASKS)) begin
			cfg_eff.leaf_ar = 4'(qbc_pkg::MAX_TASKS);
		end else begin
			cfg_eff.leaf_ar = tasks_q;
		end
		side_max = (cfg_eff.w > cfg_eff.h) ? cfg_eff.w : cfg_eff.h;
		if (side_max <= 5'd1) begin
			cfg_eff.top = 3'd0;
		end else if (side_max <= 5'd2) begin
			cfg_eff.top = 3'd1;
		end else if (side_max <= 5'd4) begin
			cfg_eff.top = 3'd2;
		end else if (side_max <= 5'd8) begin
			cfg_eff.top = 3'd3;
		end else begin
			cfg_eff.top = 3'd4;
		end
	end

	qbc_walker u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_eff),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register: load when empty or draining this cycle
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

[sim/quadtree_barrier_combiner_checker.sv]
// Checker for the quad-tree barrier combiner: predicts each outcome and compares the out words.
module quadtree_barrier_combiner_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [4:0]         cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  qbc_pkg::in_word_t  in_data,
	input  logic               out_valid,
	input  logic               out_ready,
	input  qbc_pkg::out_word_t out_data,
	output int                 outstanding,
	output int                 mismatch_count
);
	timeunit 1ns;
	timeprecision 1ps;

	// shadow of the configuration registers
	logic [4:0] mesh_w_reg;
	logic [4:0] mesh_h_reg;
	logic [3:0] tasks_reg;

	// shadow node state, one row of slots per tree level
	logic [3:0] arrived_cnt [qbc_pkg::LEVELS][qbc_pkg::SIDE*qbc_pkg::SIDE];
	logic       sense_bit   [qbc_pkg::LEVELS][qbc_pkg::SIDE*qbc_pkg::SIDE];

	qbc_pkg::out_word_t barrier_outcomes [$];
	qbc_pkg::out_word_t want;

	// Climb from the leaf, completing nodes until one is still short of its arity.
	function automatic qbc_pkg::out_word_t combine_arrival(input qbc_pkg::in_word_t a);
		int unsigned w;
		int unsigned h;
		int unsigned span;
		int unsigned levels;
		int unsigned top;
		int unsigned lv;
		int unsigned nx;
		int unsigned ny;
		int unsigned slot;
		int unsigned arity;
		int unsigned half;
		int unsigned cx;
		int unsigned cy;
		int unsigned cnt;
		bit          stop;
		qbc_pkg::out_word_t r;
		begin
			w = (mesh_w_reg > qbc_pkg::SIDE) ? qbc_pkg::SIDE : mesh_w_reg;
			h = (mesh_h_reg > qbc_pkg::SIDE) ? qbc_pkg::SIDE : mesh_h_reg;
			span = (w > h) ? w : h;
			levels = 1;
			while (levels < qbc_pkg::LEVELS && (1 << (levels - 1)) < span)
				levels++;
			top = levels - 1;
			r = '0;
			stop = 1'b0;
			if (a.arrive_x >= w || a.arrive_y >= h) begin
				r.bad_arrival = 1'b1;
			end else begin
				for (lv = 0; lv < levels && !stop; lv++) begin
					nx = a.arrive_x >> lv;
					ny = a.arrive_y >> lv;
					slot = ny * qbc_pkg::SIDE + nx;
					if (lv == 0) begin
						arity = (tasks_reg == 0) ? 1 :
							(tasks_reg > qbc_pkg::MAX_TASKS) ? qbc_pkg::MAX_TASKS : tasks_reg;
					end else begin
						// count children whose origin lies inside the mesh
						half = 1 << (lv - 1);
						arity = 0;
						for (int c = 0; c < 4; c++) begin
							cx = (nx << lv) + ((c % 2 == 1) ? half : 0);
							cy = (ny << lv) + ((c / 2 == 1) ? half : 0);
							if (cx < w && cy < h)
								arity++;
						end
					end
					cnt = arrived_cnt[lv][slot] + 1;
					if (cnt < arity) begin
						arrived_cnt[lv][slot] = cnt[3:0];
						stop = 1'b1;
					end else begin
						arrived_cnt[lv][slot] = 4'd0;
						sense_bit[lv][slot] = ~sense_bit[lv][slot];
						r.nodes_completed = r.nodes_completed + 3'd1;
						if (lv == top)
							r.all_released = 1'b1;
					end
				end
			end
			r.root_sense = sense_bit[top][0];
			return r;
		end
	endfunction

	task automatic check_field(input string name, input int unsigned want_v,
		input int unsigned got_v);
		if (want_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mesh_w_reg = 5'd16;
			mesh_h_reg = 5'd16;
			tasks_reg = 4'd1;
			for (int l = 0; l < qbc_pkg::LEVELS; l++) begin
				for (int s = 0; s < qbc_pkg::SIDE * qbc_pkg::SIDE; s++) begin
					arrived_cnt[l][s] = 4'd0;
					sense_bit[l][s] = 1'b0;
				end
			end
			barrier_outcomes.delete();
			mismatch_count = 0;
			outstanding <= 0;
		end else begin
			// retire the oldest outcome before queueing a new one
			if (out_valid && out_ready) begin
				if (barrier_outcomes.size() == 0) begin
					$error("out word %h with no arrival waiting", out_data);
					mismatch_count++;
				end else begin
					want = barrier_outcomes.pop_front();
					check_field("nodes_completed", want.nodes_completed,
						out_data.nodes_completed);
					check_field("all_released", want.all_released, out_data.all_released);
					check_field("root_sense", want.root_sense, out_data.root_sense);
					check_field("bad_arrival", want.bad_arrival, out_data.bad_arrival);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (qbc_pkg::cfg_reg_t'(cfg_index))
					qbc_pkg::CFG_MESH_WIDTH:  mesh_w_reg = cfg_data;
					qbc_pkg::CFG_MESH_HEIGHT: mesh_h_reg = cfg_data;
					qbc_pkg::CFG_TASKS:       tasks_reg = cfg_data[3:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				barrier_outcomes.push_back(combine_arrival(in_data));
			outstanding <= barrier_outcomes.size();
		end
	end

endmodule

[sim/quadtree_barrier_combiner_core_tb.sv]
// Testbench top for the quad-tree barrier combiner: clock, reset, stimulus and verdict.
module quadtree_barrier_combiner_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// index with no register behind it; a write there must change nothing
	localparam logic [1:0] CFG_SPARE = 2'd3;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [4:0]         cfg_data;
	logic               in_valid;
	logic               in_ready;
	qbc_pkg::in_word_t  in_data;
	logic               out_valid;
	logic               out_ready;
	qbc_pkg::out_word_t out_data;

	int outstanding;
	int mismatch_count;

	// percent chances of a sender gap and of a receiver stall per cycle
	int send_gap_pct;
	int stall_pct;

	quadtree_barrier_combiner_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	quadtree_barrier_combiner_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.outstanding    (outstanding),
		.mismatch_count (mismatch_count)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Receiver side: redraw ready every cycle; with no stall it stays high.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_SENDER: begin
				send_gap_pct = 57;
				stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_gap_pct = 0;
				stall_pct = 57;
			end
			IDLE_BOTH: begin
				send_gap_pct = 8;
				stall_pct = 8;
			end
			default: begin
				send_gap_pct = 0;
				stall_pct = 0;
			end
		endcase
	endtask

	// Present one register write and hold it until taken; valid stays high so
	// writes can follow back to back, the caller drops it after the last one.
	task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic set_mesh(input logic [4:0] w, input logic [4:0] h, input logic [4:0] t);
		write_reg(qbc_pkg::CFG_MESH_WIDTH, w);
		write_reg(qbc_pkg::CFG_MESH_HEIGHT, h);
		write_reg(qbc_pkg::CFG_TASKS, t);
		cfg_valid <= 1'b0;
	endtask

	// Send one arrival word: idle first at random, then hold valid and payload
	// until the handshake. Valid is left high so the next word can follow.
	task automatic arrive(input logic [3:0] x, input logic [3:0] y);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_data <= '{arrive_x: x, arrive_y: y};
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Wait until every queued outcome has come out. The first edge lets the
	// checker's count catch up with a word accepted on the current edge.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin
		#1000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int unsigned mesh_w;
		int unsigned mesh_h;
		int unsigned tasks;
		int unsigned eff_w;
		int unsigned eff_h;
		int unsigned n_items;
		logic [3:0]  ax;
		logic [3:0]  ay;

		// known values on every input before the first edge
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= qbc_pkg::CFG_MESH_WIDTH;
		cfg_data <= 5'd0;
		in_valid <= 1'b0;
		in_data <= '0;
		out_ready <= 1'b1;
		set_idling(IDLE_NONE);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. Reset setting: full 16x16 mesh, one task per cluster;
		// hit the corners so the far edges of the tree are touched.
		arrive(4'd0, 4'd0);
		arrive(4'd15, 4'd15);
		arrive(4'd0, 4'd15);
		arrive(4'd15, 4'd0);
		arrive(4'd8, 4'd7);
		drain();

		// Empty mesh: zero width makes every arrival bad; zero tasks acts as one.
		// The spare index goes first and must leave the real registers alone.
		write_reg(CFG_SPARE, 5'($urandom_range(31)));
		set_mesh(5'd0, 5'd16, 5'd0);
		arrive(4'd0, 4'd0);
		arrive(4'd15, 4'd15);
		drain();

		// Oversized sides clamp to 16; a task count above the maximum clamps too.
		set_mesh(5'd31, 5'd31, 5'd15);
		arrive(4'd15, 4'd15);
		arrive(4'd0, 4'd0);
		drain();

		// Single cluster: the leaf is the root, so each in-mesh arrival releases; the last two are out of mesh.
		set_mesh(5'd1, 5'd1, 5'd1);
		arrive(4'd0, 4'd0);
		arrive(4'd0, 4'd0);
		arrive(4'd1, 4'd0);
		arrive(4'd0, 4'd1);
		drain();

		// Two clusters in a row, three tasks each: the root has only two
		// children inside, so the sixth arrival releases.
		set_mesh(5'd2, 5'd1, 5'd3);
		repeat (3) arrive(4'd0, 4'd0);
		repeat (3) arrive(4'd1, 4'd0);
		drain();

		// Change the leaf arity mid-barrier: three arrivals banked against four,
		// then the arity drops to two and the next arrival overshoots it.
		set_mesh(5'd4, 5'd4, 5'd4);
		repeat (3) arrive(4'd1, 4'd1);
		drain();
		set_mesh(5'd4, 5'd4, 5'd2);
		arrive(4'd1, 4'd1);
		drain();

		// Random part: one setting per phase, mostly small meshes so the root
		// releases often, with full, oversized and empty meshes mixed in.
		for (int p = 0; p < 12; p++) begin
			if (p == 0) begin
				mesh_w = 16;
				mesh_h = 16;
				tasks = 1;
				n_items = 300;
			end else begin
				n_items = 120;
				case ($urandom_range(9))
					0: begin
						mesh_w = 16;
						mesh_h = 16;
						tasks = $urandom_range(0, 15);
					end
					1: begin
						mesh_w = $urandom_range(17, 31);
						mesh_h = $urandom_range(0, 31);
						tasks = $urandom_range(0, 15);
					end
					2: begin
						mesh_w = $urandom_range(0, 1);
						mesh_h = $urandom_range(0, 31);
						tasks = $urandom_range(0, 15);
					end
					default: begin
						mesh_w = $urandom_range(1, 6);
						mesh_h = $urandom_range(1, 6);
						tasks = $urandom_range(1, 3);
					end
				endcase
			end
			set_mesh(5'(mesh_w), 5'(mesh_h), 5'(tasks));
			eff_w = (mesh_w > qbc_pkg::SIDE) ? qbc_pkg::SIDE : mesh_w;
			eff_h = (mesh_h > qbc_pkg::SIDE) ? qbc_pkg::SIDE : mesh_h;
			set_idling(idle_mode_t'(p % 4));

			for (int i = 0; i < n_items; i++) begin
				// mostly in-mesh arrivals; the rest spray the whole 4-bit range
				if (eff_w == 0 || eff_h == 0 || $urandom_range(99) < 15) begin
					ax = 4'($urandom_range(15));
					ay = 4'($urandom_range(15));
				end else begin
					ax = 4'($urandom_range(eff_w - 1));
					ay = 4'($urandom_range(eff_h - 1));
				end
				arrive(ax, ay);
				// hold off mid-phase until the block has emptied out
				if (i == n_items / 2 && p % 3 == 1)
					drain();
			end
			drain();
		end

		// let any stray word surface before the verdict
		set_idling(IDLE_NONE);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && outstanding == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
